@@ hw/rtl/cbps_pkg.sv @@
// Shared types and constants for the cubic Bezier point sampler.
// Used by cbps_ctrl, cbps_dp and cubic_bezier_point_sampler_top; no dependencies.
package cbps_pkg;

   // Segment counts above this saturate.
   localparam logic [5:0]  MAX_SEGMENTS = 6'd63;
   // Curve parameter runs 0..SCALE.
   localparam logic [6:0]  SCALE        = 7'd100;
   // Quotient u = 100*k/S never exceeds 100, so seven quotient bits suffice.
   localparam int          DIV_STEPS    = 7;
   localparam int          NUM_CTRL_PTS = 4;

   // floor(n/100) = (n * RECIP_100) >> 27, exact for n < 2^20
   localparam logic [20:0] RECIP_100    = 21'd1342178;
   localparam int          SHIFT_100    = 27;
   // floor(n/10000) = (n * RECIP_10K) >> 42, exact for n below 4.9e8; the sum
   // magnitude never exceeds 32768*10000
   localparam logic [28:0] RECIP_10K    = 29'd439804652;
   localparam int          SHIFT_10K    = 42;

   typedef struct packed {
      logic       load_req;
      logic       div_init;
      logic       div_step;
      logic       wgt_sq;
      logic       wgt_cube;
      logic       wgt_scale;
      logic       mac_mul;
      logic       mac_acc;
      logic [1:0] mac_idx;
      logic       norm;
      logic       recip;
      logic       load_out;
      logic       next_point;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_point;
   } status_type;

endpackage

@@ hw/rtl/cbps_ctrl.sv @@
// Sequencer for the cubic Bezier point sampler.
// Steps the datapath through divide, weight, accumulate and scale; needs cbps_pkg.
module cbps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cbps_pkg::status_type status,
   output cbps_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PREP  = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_SQ    = 4'd3;
   localparam logic [3:0] S_CUBE  = 4'd4;
   localparam logic [3:0] S_SCALE = 4'd5;
   localparam logic [3:0] S_MAC   = 4'd6;
   localparam logic [3:0] S_NORM  = 4'd7;
   localparam logic [3:0] S_RECIP = 4'd8;
   localparam logic [3:0] S_EMIT  = 4'd9;

   localparam logic [2:0] DIV_LAST = 3'(cbps_pkg::DIV_STEPS - 1);
   localparam logic [2:0] MAC_LAST = 3'(cbps_pkg::NUM_CTRL_PTS);

   logic [3:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;

   // take nothing while reset is held
   assign req_ready = (state_ff == S_IDLE) && !reset;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_PREP;
            end
         end
         S_PREP: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            cmd.wgt_sq = 1'b1;
            state_in   = S_CUBE;
         end
         S_CUBE: begin
            cmd.wgt_cube = 1'b1;
            state_in     = S_SCALE;
         end
         S_SCALE: begin
            cmd.wgt_scale = 1'b1;
            cnt_in        = '0;
            state_in      = S_MAC;
         end
         S_MAC: begin
            // multiply on counts 0..3, accumulate the registered product one count later
            cmd.mac_mul = (cnt_ff != MAC_LAST);
            cmd.mac_idx = cnt_ff[1:0];
            cmd.mac_acc = (cnt_ff != 3'd0);
            cnt_in      = cnt_ff + 3'd1;
            if (cnt_ff == MAC_LAST) begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            cmd.norm = 1'b1;
            state_in = S_RECIP;
         end
         S_RECIP: begin
            cmd.recip = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.last_point) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.next_point = 1'b1;
                  state_in       = S_PREP;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ hw/rtl/cbps_dp.sv @@
// Datapath for the cubic Bezier point sampler: divider, blend weights,
// multiply-accumulate, scaling and the output register. Needs cbps_pkg.
module cbps_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  cbps_pkg::cmd_type    cmd,
   output cbps_pkg::status_type status,
   input  logic signed [15:0]   req_p0_x,
   input  logic signed [15:0]   req_p0_y,
   input  logic signed [15:0]   req_p1_x,
   input  logic signed [15:0]   req_p1_y,
   input  logic signed [15:0]   req_p2_x,
   input  logic signed [15:0]   req_p2_y,
   input  logic signed [15:0]   req_p3_x,
   input  logic signed [15:0]   req_p3_y,
   input  logic [5:0]           req_segments,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [15:0]   rsp_x_out,
   output logic signed [15:0]   rsp_y_out,
   output logic [5:0]           rsp_point_index,
   output logic                 rsp_last
);

   localparam int NP = cbps_pkg::NUM_CTRL_PTS;

   // request
   logic signed [15:0] px_ff [NP];
   logic signed [15:0] px_in [NP];
   logic signed [15:0] py_ff [NP];
   logic signed [15:0] py_in [NP];
   logic [5:0]  seg_ff, seg_in;
   logic [5:0]  k_ff, k_in;
   logic [12:0] num_ff, num_in;
   // divider
   logic [5:0]  rem_ff, rem_in;
   logic [6:0]  quo_ff, quo_in;
   // weights
   logic [6:0]  u_ff, u_in;
   logic [6:0]  v_ff, v_in;
   logic [13:0] uu_ff, uu_in;
   logic [13:0] vv_ff, vv_in;
   logic [19:0] n_ff [NP];
   logic [19:0] n_in [NP];
   logic [13:0] b_ff [NP];
   logic [13:0] b_in [NP];
   // accumulate and scale
   logic signed [30:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic signed [31:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [28:0] mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic        neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [15:0] q_x_ff, q_x_in, q_y_ff, q_y_in;
   // output register
   logic               out_valid_ff, out_valid_in;
   logic signed [15:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [5:0]         out_idx_ff, out_idx_in;
   logic               out_last_ff, out_last_in;

   logic [6:0]  div_t;
   logic        div_ge;
   logic [6:0]  div_diff;
   logic [6:0]  u_sel;
   logic [6:0]  v_sel;
   logic [8:0]  u3;
   logic [8:0]  v3;
   logic [40:0] scl [NP];
   logic signed [14:0] b_sgn;
   logic signed [31:0] abs_x, abs_y;
   logic [57:0] rq_x, rq_y;

   assign status.out_free   = !out_valid_ff || rsp_ready;
   assign status.last_point = (k_ff == seg_ff);

   assign rsp_valid       = out_valid_ff;
   assign rsp_x_out       = out_x_ff;
   assign rsp_y_out       = out_y_ff;
   assign rsp_point_index = out_idx_ff;
   assign rsp_last        = out_last_ff;

   // one restoring step: bring in the next dividend bit, subtract if it fits
   assign div_t    = {rem_ff, quo_ff[6]};
   assign div_ge   = (div_t >= {1'b0, seg_ff});
   assign div_diff = div_t - {1'b0, seg_ff};

   // zero segments emits the start point only
   assign u_sel = (seg_ff == 6'd0) ? 7'd0 : quo_ff;
   assign v_sel = cbps_pkg::SCALE - u_sel;
   assign u3    = 9'(u_ff) + {u_ff, 1'b0};
   assign v3    = 9'(v_ff) + {v_ff, 1'b0};

   assign b_sgn = $signed({1'b0, b_ff[cmd.mac_idx]});
   assign abs_x = acc_x_ff[31] ? -acc_x_ff : acc_x_ff;
   assign abs_y = acc_y_ff[31] ? -acc_y_ff : acc_y_ff;
   assign rq_x  = 58'(mag_x_ff) * 58'(cbps_pkg::RECIP_10K);
   assign rq_y  = 58'(mag_y_ff) * 58'(cbps_pkg::RECIP_10K);

   always_comb begin
      for (int i = 0; i < NP; i++) begin
         scl[i] = 41'(n_ff[i]) * 41'(cbps_pkg::RECIP_100);
      end
   end

   always_comb begin
      for (int i = 0; i < NP; i++) begin
         px_in[i] = px_ff[i];
         py_in[i] = py_ff[i];
         n_in[i]  = n_ff[i];
         b_in[i]  = b_ff[i];
      end
      seg_in    = seg_ff;
      k_in      = k_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      uu_in     = uu_ff;
      vv_in     = vv_ff;
      prod_x_in = prod_x_ff;
      prod_y_in = prod_y_ff;
      acc_x_in  = acc_x_ff;
      acc_y_in  = acc_y_ff;
      mag_x_in  = mag_x_ff;
      mag_y_in  = mag_y_ff;
      neg_x_in  = neg_x_ff;
      neg_y_in  = neg_y_ff;
      q_x_in    = q_x_ff;
      q_y_in    = q_y_ff;
      out_x_in  = out_x_ff;
      out_y_in  = out_y_ff;
      out_idx_in  = out_idx_ff;
      out_last_in = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      if (cmd.load_req) begin
         px_in[0] = req_p0_x;
         px_in[1] = req_p1_x;
         px_in[2] = req_p2_x;
         px_in[3] = req_p3_x;
         py_in[0] = req_p0_y;
         py_in[1] = req_p1_y;
         py_in[2] = req_p2_y;
         py_in[3] = req_p3_y;
         seg_in   = (req_segments > cbps_pkg::MAX_SEGMENTS) ?
                    cbps_pkg::MAX_SEGMENTS : req_segments;
         k_in     = '0;
         num_in   = '0;
      end
      if (cmd.next_point) begin
         k_in   = k_ff + 6'd1;
         num_in = num_ff + 13'(cbps_pkg::SCALE);
      end
      // quotient fits seven bits, so the upper dividend bits start as the remainder
      if (cmd.div_init) begin
         rem_in = num_ff[12:7];
         quo_in = num_ff[6:0];
      end
      if (cmd.div_step) begin
         rem_in = div_ge ? div_diff[5:0] : div_t[5:0];
         quo_in = {quo_ff[5:0], div_ge};
      end
      if (cmd.wgt_sq) begin
         u_in  = u_sel;
         v_in  = v_sel;
         uu_in = 14'(u_sel) * 14'(u_sel);
         vv_in = 14'(v_sel) * 14'(v_sel);
      end
      if (cmd.wgt_cube) begin
         n_in[0] = 20'(vv_ff) * 20'(v_ff);
         n_in[1] = 20'(vv_ff) * 20'(u3);
         n_in[2] = 20'(uu_ff) * 20'(v3);
         n_in[3] = 20'(uu_ff) * 20'(u_ff);
      end
      if (cmd.wgt_scale) begin
         for (int i = 0; i < NP; i++) begin
            b_in[i] = scl[i][cbps_pkg::SHIFT_100 +: 14];
         end
         acc_x_in = '0;
         acc_y_in = '0;
      end
      if (cmd.mac_mul) begin
         prod_x_in = px_ff[cmd.mac_idx] * b_sgn;
         prod_y_in = py_ff[cmd.mac_idx] * b_sgn;
      end
      if (cmd.mac_acc) begin
         acc_x_in = acc_x_ff + 32'(prod_x_ff);
         acc_y_in = acc_y_ff + 32'(prod_y_ff);
      end
      // divide magnitudes so the quotient truncates toward zero
      if (cmd.norm) begin
         neg_x_in = acc_x_ff[31];
         neg_y_in = acc_y_ff[31];
         mag_x_in = abs_x[28:0];
         mag_y_in = abs_y[28:0];
      end
      if (cmd.recip) begin
         q_x_in = rq_x[cbps_pkg::SHIFT_10K +: 16];
         q_y_in = rq_y[cbps_pkg::SHIFT_10K +: 16];
      end
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_x_in     = neg_x_ff ? -$signed(q_x_ff) : $signed(q_x_ff);
         out_y_in     = neg_y_ff ? -$signed(q_y_ff) : $signed(q_y_ff);
         out_idx_in   = k_ff;
         out_last_in  = (k_ff == seg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NP; i++) begin
         px_ff[i] <= px_in[i];
         py_ff[i] <= py_in[i];
         n_ff[i]  <= n_in[i];
         b_ff[i]  <= b_in[i];
      end
      seg_ff      <= seg_in;
      k_ff        <= k_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      uu_ff       <= uu_in;
      vv_ff       <= vv_in;
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      acc_x_ff    <= acc_x_in;
      acc_y_ff    <= acc_y_in;
      mag_x_ff    <= mag_x_in;
      mag_y_ff    <= mag_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      q_x_ff      <= q_x_in;
      q_y_ff      <= q_y_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
   end

endmodule

@@ hw/rtl/cubic_bezier_point_sampler_top.sv @@
// Cubic Bezier point sampler: one request of four control points and a segment
// count S yields S+1 sample points, the last one flagged (one point for S = 0).
// Each point passes through the shared restoring divider that forms
// u = 100*k/S (a load, then seven steps), the blend-weight products, the
// single multiply-accumulate lane that walks the four control points, the
// 1/10000 scaling and the hand-off, which waits for a free output register.
// A new request is taken once the final point sits in the output register.
// Needs cbps_pkg, cbps_ctrl and cbps_dp.
module cubic_bezier_point_sampler_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_p0_x,
   input  logic signed [15:0] req_p0_y,
   input  logic signed [15:0] req_p1_x,
   input  logic signed [15:0] req_p1_y,
   input  logic signed [15:0] req_p2_x,
   input  logic signed [15:0] req_p2_y,
   input  logic signed [15:0] req_p3_x,
   input  logic signed [15:0] req_p3_y,
   input  logic [5:0]         req_segments,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_x_out,
   output logic signed [15:0] rsp_y_out,
   output logic [5:0]         rsp_point_index,
   output logic               rsp_last
);

   cbps_pkg::cmd_type    cmd;
   cbps_pkg::status_type status;

   cbps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cbps_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_p0_x        (req_p0_x),
      .req_p0_y        (req_p0_y),
      .req_p1_x        (req_p1_x),
      .req_p1_y        (req_p1_y),
      .req_p2_x        (req_p2_x),
      .req_p2_y        (req_p2_y),
      .req_p3_x        (req_p3_x),
      .req_p3_y        (req_p3_y),
      .req_segments    (req_segments),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_x_out       (rsp_x_out),
      .rsp_y_out       (rsp_y_out),
      .rsp_point_index (rsp_point_index),
      .rsp_last        (rsp_last)
   );

endmodule

@@ tb/cubic_bezier_point_sampler_top_test.sv @@
// Self-checking test of cubic_bezier_point_sampler_top: curve requests go in over
// valid/ready, every sample point is checked against a local predictor.
// Needs cbps_pkg and the sampler RTL; reads no files.
`timescale 1ns / 1ps

module cubic_bezier_point_sampler_top_test;

   localparam int DIR_ROWS       = 16;
   localparam int RANDOM_CURVES  = 434;
   localparam int HOLD_OFF       = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int POINT_CYCLES   = 19;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [15:0] p0_x;
      logic [15:0] p0_y;
      logic [15:0] p1_x;
      logic [15:0] p1_y;
      logic [15:0] p2_x;
      logic [15:0] p2_y;
      logic [15:0] p3_x;
      logic [15:0] p3_y;
      logic [5:0]  segments;
   } curve_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [5:0]  idx;
      logic        last;
   } sample_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_p0_x;
   logic signed [15:0] req_p0_y;
   logic signed [15:0] req_p1_x;
   logic signed [15:0] req_p1_y;
   logic signed [15:0] req_p2_x;
   logic signed [15:0] req_p2_y;
   logic signed [15:0] req_p3_x;
   logic signed [15:0] req_p3_y;
   logic [5:0]         req_segments;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_x_out;
   logic signed [15:0] rsp_y_out;
   logic [5:0]         rsp_point_index;
   logic               rsp_last;

   sample_type expected_points[$];
   int         curves_sent    = 0;
   int         points_checked = 0;
   int         mismatches     = 0;
   int         hold_offs      = 0;
   int         idle_cycles    = 0;

   // Columns: p0 x,y  p1 x,y  p2 x,y  p3 x,y  segments | start x,y  end x,y.
   // Endpoints are p0 and p3 (p0 alone for zero segments); points in between come from the predictor.
   int dir_tab [DIR_ROWS][13] = '{
      '{     0,      0,      0,      0,      0,      0,      0,      0,  0,
             0,      0,      0,      0},
      '{ 32767, -32768,    100,   -100,     -5,      5,      1,      1,  0,
         32767, -32768,  32767, -32768},
      '{-32768,  32767,      0,      0,      0,      0,  32767, -32768,  1,
        -32768,  32767,  32767, -32768},
      '{ 32767,  32767,  32767,  32767,  32767,  32767,  32767,  32767, 63,
         32767,  32767,  32767,  32767},
      '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 63,
        -32768, -32768, -32768, -32768},
      '{ 32767, -32768, -32768,  32767,  32767, -32768, -32768,  32767,  3,
         32767, -32768, -32768,  32767},
      '{     0,      0,  32767,  32767, -32768, -32768,      0,      0,  2,
             0,      0,      0,      0},
      '{    -1,     -1,     -1,     -1,     -1,     -1,     -1,     -1,  7,
            -1,     -1,     -1,     -1},
      '{     1,     -1,      1,     -1,      1,     -1,      1,     -1, 50,
             1,     -1,      1,     -1},
      '{-32768, -32768,  32767,  32767,  32767,  32767, -32768, -32768, 33,
        -32768, -32768, -32768, -32768},
      '{  1000,  -2000,  -3000,   4000,   5000,  -6000,   7000,  -8000,  6,
          1000,  -2000,   7000,  -8000},
      '{ 16384, -16384, -16384,  16384,  16384, -16384, -16384,  16384, 32,
         16384, -16384, -16384,  16384},
      '{ 21845, -21846,  21845, -21846,  21845, -21846,  21845, -21846, 21,
         21845, -21846,  21845, -21846},
      '{-21846,  21845, -21846,  21845, -21846,  21845, -21846,  21845, 42,
        -21846,  21845, -21846,  21845},
      '{ 12345, -12345,   -300,    700,   9999,     -1,     -7,  32000,  4,
         12345, -12345,     -7,  32000},
      '{     0,      0, -32768, -32768, -32768, -32768,  32767,  32767, 63,
             0,      0,  32767,  32767}
   };

   cubic_bezier_point_sampler_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_p0_x        (req_p0_x),
      .req_p0_y        (req_p0_y),
      .req_p1_x        (req_p1_x),
      .req_p1_y        (req_p1_y),
      .req_p2_x        (req_p2_x),
      .req_p2_y        (req_p2_y),
      .req_p3_x        (req_p3_x),
      .req_p3_y        (req_p3_y),
      .req_segments    (req_segments),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_x_out       (rsp_x_out),
      .rsp_y_out       (rsp_y_out),
      .rsp_point_index (rsp_point_index),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Sample k of a curve: truncated blend weights, then a sum divided by 10000
   // that truncates toward zero.
   function automatic sample_type bezier_point(input curve_type c, input int k);
      longint     px[4];
      longint     py[4];
      longint     w[4];
      longint     scale;
      longint     segs;
      longint     u;
      longint     v;
      longint     sx;
      longint     sy;
      sample_type s;
      px[0] = $signed(c.p0_x);
      py[0] = $signed(c.p0_y);
      px[1] = $signed(c.p1_x);
      py[1] = $signed(c.p1_y);
      px[2] = $signed(c.p2_x);
      py[2] = $signed(c.p2_y);
      px[3] = $signed(c.p3_x);
      py[3] = $signed(c.p3_y);
      scale = longint'(cbps_pkg::SCALE);
      segs  = longint'(c.segments);
      u     = (segs == 0) ? 0 : (longint'(k) * scale) / segs;
      v     = scale - u;
      w[0]  = (v * v * v) / scale;
      w[1]  = (3 * u * v * v) / scale;
      w[2]  = (3 * u * u * v) / scale;
      w[3]  = (u * u * u) / scale;
      sx    = 0;
      sy    = 0;
      for (int i = 0; i < cbps_pkg::NUM_CTRL_PTS; i++) begin
         sx += px[i] * w[i];
         sy += py[i] * w[i];
      end
      sx     = sx / (scale * scale);
      sy     = sy / (scale * scale);
      s.x    = sx[15:0];
      s.y    = sy[15:0];
      s.idx  = k[5:0];
      s.last = (longint'(k) == segs);
      return s;
   endfunction

   function automatic logic [15:0] rand_coord();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 16'sd32767;
         1: return -16'sd32768;
         2: return 16'($urandom_range(0, 200) - 100);
         default: return 16'($urandom);
      endcase
   endfunction

   // Keep most curves short so the run stays quick; long ones still show up.
   function automatic curve_type rand_curve();
      curve_type c;
      int        r;
      c.p0_x = rand_coord();
      c.p0_y = rand_coord();
      c.p1_x = rand_coord();
      c.p1_y = rand_coord();
      c.p2_x = rand_coord();
      c.p2_y = rand_coord();
      c.p3_x = rand_coord();
      c.p3_y = rand_coord();
      r = $urandom_range(0, 99);
      if (r < 10)
         c.segments = 6'd0;
      else if (r < 75)
         c.segments = 6'($urandom_range(1, 8));
      else if (r < 90)
         c.segments = 6'($urandom_range(9, 31));
      else
         c.segments = 6'($urandom_range(32, int'(cbps_pkg::MAX_SEGMENTS)));
      return c;
   endfunction

   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 80);
   endfunction

   // Offer one curve and hold it until the block takes it.
   task automatic send_curve(input curve_type c);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_p0_x     <= c.p0_x;
      req_p0_y     <= c.p0_y;
      req_p1_x     <= c.p1_x;
      req_p1_y     <= c.p1_y;
      req_p2_x     <= c.p2_x;
      req_p2_y     <= c.p2_y;
      req_p3_x     <= c.p3_x;
      req_p3_y     <= c.p3_y;
      req_segments <= c.segments;
      req_valid    <= 1'b1;
      do @(posedge clock); while (!req_ready);
      curves_sent++;
   endtask

   task automatic queue_curve_points(input curve_type c, input bit typed,
                                     input int x0, input int y0,
                                     input int xn, input int yn);
      sample_type s;
      for (int k = 0; k <= int'(c.segments); k++) begin
         s = bezier_point(c, k);
         if (typed && k == 0) begin
            s.x = 16'(x0);
            s.y = 16'(y0);
         end
         if (typed && k == int'(c.segments)) begin
            s.x = 16'(xn);
            s.y = 16'(yn);
         end
         expected_points.push_back(s);
      end
   endtask

   // Drop valid and wait until every outstanding point is back.
   task automatic drain_pause();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_points.size() != 0);
   endtask

   initial begin : stimulus
      curve_type c;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_p0_x     <= '0;
      req_p0_y     <= '0;
      req_p1_x     <= '0;
      req_p1_y     <= '0;
      req_p2_x     <= '0;
      req_p2_y     <= '0;
      req_p3_x     <= '0;
      req_p3_y     <= '0;
      req_segments <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         c.p0_x     = 16'(dir_tab[r][0]);
         c.p0_y     = 16'(dir_tab[r][1]);
         c.p1_x     = 16'(dir_tab[r][2]);
         c.p1_y     = 16'(dir_tab[r][3]);
         c.p2_x     = 16'(dir_tab[r][4]);
         c.p2_y     = 16'(dir_tab[r][5]);
         c.p3_x     = 16'(dir_tab[r][6]);
         c.p3_y     = 16'(dir_tab[r][7]);
         c.segments = 6'(dir_tab[r][8]);
         send_curve(c);
         queue_curve_points(c, 1'b1, dir_tab[r][9], dir_tab[r][10],
                            dir_tab[r][11], dir_tab[r][12]);
      end
      drain_pause();

      for (int i = 0; i < RANDOM_CURVES; i++) begin
         if (i == RANDOM_CURVES / 2)
            drain_pause();
         c = rand_curve();
         send_curve(c);
         queue_curve_points(c, 1'b0, 0, 0, 0, 0);
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (expected_points.size() != 0);
      repeat (4 * POINT_CYCLES) @(posedge clock);

      $display("Run covered %0d curve requests (%0d directed) and %0d sample points,",
               curves_sent, DIR_ROWS, points_checked);
      $display("segment counts 0..63, coordinate extremes, %0d long output stalls; %0d errors",
               hold_offs, mismatches);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Output side: random ready pattern, plus two long hold-offs that back the
   // block up into its input.
   initial begin : rsp_pacing
      int gap;
      int burst;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ((hold_offs == 0 && points_checked >= 100) ||
             (hold_offs == 1 && points_checked >= 1200)) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
            hold_offs++;
         end else begin
            gap   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 60);
            burst = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 20)
                                                 : $urandom_range(50, 300);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_ready <= 1'b1;
            repeat (burst) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : point_check
      sample_type got;
      sample_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{x: rsp_x_out, y: rsp_y_out, idx: rsp_point_index, last: rsp_last};
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected point: x=%0d y=%0d k=%0d last=%0b",
                        $signed(got.x), $signed(got.y), got.idx, got.last);
         end else begin
            want = expected_points.pop_front();
            points_checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("point mismatch: want x=%0d y=%0d k=%0d last=%0b,",
                           $signed(want.x), $signed(want.y), want.idx, want.last,
                           " got x=%0d y=%0d k=%0d last=%0b",
                           $signed(got.x), $signed(got.y), got.idx, got.last);
            end
         end
      end
   end

   // Count cycles with no item moving on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: nothing accepted for %0d cycles, %0d points outstanding",
                  idle_cycles, expected_points.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
